### design/fxf_pkg.sv
// Shared types and constants for the frame packetizer with XOR parity.
// Used by every module but fxf_ram; depends on nothing else.
package fxf_pkg;

   // Default geometry, the defaults of the top-level parameters.
   localparam int CHUNK_BYTES_DEF = 1300;
   localparam int GROUP_SPAN_DEF  = 8;
   localparam int MAX_GROUPS_DEF  = 64;

   // Packet header layout.
   localparam int HDR_BYTES = 28;
   localparam logic [7:0] MAGIC_0 = 8'h55;
   localparam logic [7:0] MAGIC_1 = 8'h44;
   localparam logic [7:0] MAGIC_2 = 8'h50;
   localparam logic [7:0] MAGIC_3 = 8'h56;

   // Header flag bits.
   localparam logic [7:0] FLAG_KEY     = 8'h01;
   localparam logic [7:0] FLAG_CFG     = 8'h02;
   localparam logic [7:0] FLAG_HEVC    = 8'h04;
   localparam logic [7:0] FLAG_PARITY  = 8'h08;
   localparam logic [7:0] AUD_FLAG     = 8'h10;
   localparam logic [7:0] AUD_CFG_FLAG = 8'h20;

   // Input function codes.
   localparam logic FUNC_PAYLOAD = 1'b0;
   localparam logic FUNC_PULL    = 1'b1;

   // Depth of the command queue between front and back.
   localparam int CMD_DEPTH = 8;
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   // One accepted input item.
   typedef struct packed {
      logic        func;
      logic [7:0]  data_byte;
      logic [26:0] frame_size;
      logic [63:0] timestamp_ms;
      logic        is_keyframe;
      logic        is_codec_config;
      logic        is_hevc;
      logic        is_audio;
   } fxf_item_type;

   // One command for the back end: an optional header, then one byte.
   typedef struct packed {
      logic        hdr;
      logic [31:0] seq;
      logic [63:0] ts;
      logic [7:0]  flags;
      logic [15:0] idx;
      logic [15:0] cnt;
      logic [26:0] size;
      logic [7:0]  span;
      logic [7:0]  data;
      logic        pend;
      logic        fend;
      logic        rej;
   } fxf_cmd_type;

   // Push side of the command queue.
   typedef struct packed {
      logic        valid;
      fxf_cmd_type cmd;
   } fxf_push_type;

endpackage

### design/fxf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; read returns the old contents on a same-cycle write.
module fxf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### design/fxf_front.sv
// Front end: accepts items, works out frame geometry, keeps the framing state,
// accumulates parity in the parity RAM and issues commands. Uses fxf_pkg, fxf_ram.
module fxf_front
   import fxf_pkg::*;
#(
   parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
   parameter int GROUP_SPAN  = GROUP_SPAN_DEF,
   parameter int MAX_GROUPS  = MAX_GROUPS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_accept,
   input  fxf_item_type         in_item,
   input  logic [CMD_CNT_W-1:0] cmd_count,
   output logic                 full,
   output fxf_push_type         cmd_push
);

   localparam int X_W    = 28;
   localparam int M_W    = 31;
   localparam int P_W    = X_W + M_W;
   localparam int DIV2   = CHUNK_BYTES * GROUP_SPAN;
   localparam int S1     = X_W + $clog2(CHUNK_BYTES) + 1;
   localparam int S2     = X_W + $clog2(DIV2) + 1;
   localparam logic [63:0] M1 =
      ((64'd1 << S1) + 64'(CHUNK_BYTES) - 64'd1) / 64'(CHUNK_BYTES);
   localparam logic [63:0] M2 = ((64'd1 << S2) + 64'(DIV2) - 64'd1) / 64'(DIV2);
   localparam int CNT_W  = 22;
   localparam int GCR_W  = 21;
   localparam int GC_W   = $clog2(MAX_GROUPS + 1);
   localparam int CG_W   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int CP_W   = $clog2(CHUNK_BYTES);
   localparam int DEPTH  = MAX_GROUPS * CHUNK_BYTES;
   localparam int ADDR_W = $clog2(DEPTH);

   // Stage A: captured item and chunk / group dividends.
   logic                  a_v_ff;
   fxf_item_type          a_item_ff;
   logic [X_W-1:0]        a_x1_ff, a_x2_ff;
   // Stage B: reciprocal products.
   logic                  b_v_ff;
   fxf_item_type          b_item_ff;
   logic [P_W-1:0]        b_p1_ff, b_p2_ff;
   // Stage D: command waiting for parity RAM data.
   logic                  d_v_ff, d_v_in;
   fxf_cmd_type           d_cmd_ff, d_cmd_in;
   logic                  d_par_ff, d_par_in;
   logic                  d_we_ff, d_we_in;
   logic                  d_first_ff, d_first_in;
   logic [ADDR_W-1:0]     d_addr_ff, d_addr_in;
   // Last parity write, for the read-after-write bypass.
   logic                  lw_v_ff;
   logic [ADDR_W-1:0]     lw_addr_ff;
   logic [7:0]            lw_data_ff;

   // Framing state.
   logic [31:0]           vseq_ff, vseq_in, aseq_ff, aseq_in;
   logic [26:0]           offset_ff, offset_in;
   logic [15:0]           frag_ff, frag_in;
   logic [CP_W-1:0]       cpos_ff, cpos_in;
   logic [GC_W-1:0]       gc_ff, gc_in;
   logic [CG_W-1:0]       cg_ff, cg_in;
   logic [ADDR_W-1:0]     base_ff, base_in;
   logic                  first_ff, first_in;
   logic [63:0]           lat_ts_ff, lat_ts_in;
   logic [26:0]           lat_size_ff, lat_size_in;
   logic [15:0]           lat_cnt_ff, lat_cnt_in;
   logic [31:0]           lat_seq_ff, lat_seq_in;
   logic [7:0]            lat_flags_ff, lat_flags_in;
   logic [GC_W-1:0]       dgrp_ff, dgrp_in;
   logic [CP_W-1:0]       dpos_ff, dpos_in;
   logic [ADDR_W-1:0]     dbase_ff, dbase_in;

   // Stage C combinational values.
   logic [P_W-1:0]        p1_sh, p2_sh;
   logic [CNT_W-1:0]      cnt_new;
   logic [GCR_W-1:0]      gc_raw;
   logic                  drain_busy, is_pay, is_pull, c_start, c_reject;
   logic [31:0]           st_seq;
   logic [7:0]            st_flags;
   logic [15:0]           st_cnt;
   logic [GC_W-1:0]       st_gc;
   logic [26:0]           e_size;
   logic [7:0]            e_flags;
   logic [31:0]           e_seq;
   logic [63:0]           e_ts;
   logic [15:0]           e_cnt, e_frag;
   logic [GC_W-1:0]       e_gc;
   logic [CP_W-1:0]       e_cpos;
   logic [CG_W-1:0]       e_cg;
   logic [ADDR_W-1:0]     e_base, c_raddr;
   logic                  e_first, last, chunk_end, pkt_last, cg_wrap;
   logic [7:0]            ram_rdata, rd_fwd, par_wdata;
   fxf_cmd_type           out_cmd;

   // Credit check: every item in flight has a queue slot reserved.
   assign full = (CMD_CNT_W + 2)'(cmd_count) + (CMD_CNT_W + 2)'(a_v_ff)
               + (CMD_CNT_W + 2)'(b_v_ff) + (CMD_CNT_W + 2)'(d_v_ff)
               >= (CMD_CNT_W + 2)'(CMD_DEPTH);

   // Stages A and B: dividends, then multiplication by reciprocals.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else begin
         a_v_ff <= in_accept;
         b_v_ff <= a_v_ff;
      end
      a_item_ff <= in_item;
      a_x1_ff   <= X_W'(in_item.frame_size) + X_W'(CHUNK_BYTES - 1);
      a_x2_ff   <= X_W'(in_item.frame_size) + X_W'(DIV2 - 1);
      b_item_ff <= a_item_ff;
      b_p1_ff   <= P_W'(a_x1_ff) * P_W'(M1[M_W-1:0]);
      b_p2_ff   <= P_W'(a_x2_ff) * P_W'(M2[M_W-1:0]);
   end

   // Fragment count and parity group count of the item's frame size.
   always_comb begin
      p1_sh   = b_p1_ff >> S1;
      p2_sh   = b_p2_ff >> S2;
      cnt_new = p1_sh[CNT_W-1:0];
      gc_raw  = p2_sh[GCR_W-1:0];
   end

   // Classification of the item in stage C.
   assign drain_busy = dgrp_ff != '0;
   assign is_pay     = b_v_ff && (b_item_ff.func == FUNC_PAYLOAD);
   assign is_pull    = b_v_ff && (b_item_ff.func == FUNC_PULL) && drain_busy;
   assign c_reject   = is_pay && (drain_busy ||
                       (offset_ff == '0 && b_item_ff.frame_size == '0));
   assign c_start    = is_pay && !c_reject && offset_ff == '0;

   // Header values for a frame that starts with this item.
   always_comb begin
      if (b_item_ff.is_audio) begin
         st_seq   = aseq_ff + 32'd1;
         st_flags = AUD_FLAG | (b_item_ff.is_codec_config ? AUD_CFG_FLAG : 8'h00);
         st_cnt   = 16'd1;
         st_gc    = '0;
      end else begin
         st_seq   = vseq_ff + 32'd1;
         st_flags = (b_item_ff.is_keyframe ? FLAG_KEY : 8'h00)
                  | ((b_item_ff.is_codec_config && !b_item_ff.is_keyframe) ?
                     FLAG_CFG : 8'h00)
                  | (b_item_ff.is_hevc ? FLAG_HEVC : 8'h00);
         st_cnt   = cnt_new[15:0];
         if (cnt_new > CNT_W'(1)) begin
            st_gc = (gc_raw > GCR_W'(MAX_GROUPS)) ? GC_W'(MAX_GROUPS)
                                                  : gc_raw[GC_W-1:0];
         end else begin
            st_gc = '0;
         end
      end
   end

   // Effective frame state for this item.
   always_comb begin
      e_size  = c_start ? b_item_ff.frame_size   : lat_size_ff;
      e_flags = c_start ? st_flags               : lat_flags_ff;
      e_seq   = c_start ? st_seq                 : lat_seq_ff;
      e_ts    = c_start ? b_item_ff.timestamp_ms : lat_ts_ff;
      e_cnt   = c_start ? st_cnt                 : lat_cnt_ff;
      e_gc    = c_start ? st_gc                  : gc_ff;
      e_cpos  = c_start ? '0                     : cpos_ff;
      e_frag  = c_start ? '0                     : frag_ff;
      e_cg    = c_start ? '0                     : cg_ff;
      e_base  = c_start ? '0                     : base_ff;
      e_first = c_start ? 1'b1                   : first_ff;
      last      = (28'(offset_ff) + 28'd1) >= 28'(e_size);
      chunk_end = last || ((CP_W + 1)'(e_cpos) + (CP_W + 1)'(1)
                           >= (CP_W + 1)'(CHUNK_BYTES));
      cg_wrap   = (GC_W + 1)'(e_cg) + (GC_W + 1)'(1) >= (GC_W + 1)'(e_gc);
      pkt_last  = (CP_W + 1)'(dpos_ff) + (CP_W + 1)'(1) >= (CP_W + 1)'(CHUNK_BYTES);
   end

   // Stage C: state update and command build.
   always_comb begin
      vseq_in      = vseq_ff;
      aseq_in      = aseq_ff;
      offset_in    = offset_ff;
      frag_in      = frag_ff;
      cpos_in      = cpos_ff;
      gc_in        = gc_ff;
      cg_in        = cg_ff;
      base_in      = base_ff;
      first_in     = first_ff;
      lat_ts_in    = lat_ts_ff;
      lat_size_in  = lat_size_ff;
      lat_cnt_in   = lat_cnt_ff;
      lat_seq_in   = lat_seq_ff;
      lat_flags_in = lat_flags_ff;
      dgrp_in      = dgrp_ff;
      dpos_in      = dpos_ff;
      dbase_in     = dbase_ff;
      d_v_in       = 1'b0;
      d_cmd_in     = '0;
      d_par_in     = 1'b0;
      d_we_in      = 1'b0;
      d_first_in   = 1'b0;
      d_addr_in    = e_base + ADDR_W'(e_cpos);
      c_raddr      = e_base + ADDR_W'(e_cpos);

      d_cmd_in.seq  = e_seq;
      d_cmd_in.ts   = e_ts;
      d_cmd_in.flags = e_flags;
      d_cmd_in.cnt  = e_cnt;
      d_cmd_in.size = e_size;

      if (c_reject) begin
         // Refused payload byte: a single flagged result.
         d_v_in       = 1'b1;
         d_cmd_in.rej = 1'b1;
      end else if (is_pull) begin
         // One parity byte, with a header in front of each parity packet.
         d_v_in         = 1'b1;
         d_par_in       = 1'b1;
         d_addr_in      = dbase_ff + ADDR_W'(dpos_ff);
         c_raddr        = dbase_ff + ADDR_W'(dpos_ff);
         d_cmd_in.hdr   = dpos_ff == '0;
         d_cmd_in.flags = lat_flags_ff | FLAG_PARITY;
         d_cmd_in.idx   = 16'(dgrp_ff - GC_W'(1));
         d_cmd_in.span  = GROUP_SPAN[7:0];
         d_cmd_in.pend  = pkt_last;
         d_cmd_in.fend  = pkt_last && (dgrp_ff >= gc_ff);
         if (pkt_last) begin
            dpos_in  = '0;
            dbase_in = dbase_ff + ADDR_W'(CHUNK_BYTES);
            dgrp_in  = (dgrp_ff >= gc_ff) ? '0 : dgrp_ff + GC_W'(1);
         end else begin
            dpos_in = dpos_ff + CP_W'(1);
         end
      end else if (is_pay) begin
         d_v_in        = 1'b1;
         d_cmd_in.data = b_item_ff.data_byte;
         if (c_start) begin
            lat_ts_in    = b_item_ff.timestamp_ms;
            lat_size_in  = b_item_ff.frame_size;
            lat_cnt_in   = st_cnt;
            lat_seq_in   = st_seq;
            lat_flags_in = st_flags;
            gc_in        = st_gc;
            if (b_item_ff.is_audio) begin
               aseq_in = st_seq;
            end else begin
               vseq_in = st_seq;
            end
            frag_in  = '0;
            cpos_in  = '0;
            cg_in    = '0;
            base_in  = '0;
            first_in = 1'b1;
         end
         if ((e_flags & AUD_FLAG) != 8'h00) begin
            // Audio: the whole frame is one packet.
            d_cmd_in.hdr  = offset_ff == '0;
            d_cmd_in.idx  = '0;
            d_cmd_in.span = '0;
            d_cmd_in.pend = last;
            d_cmd_in.fend = last;
         end else begin
            // Video: one packet per chunk, parity into the current group if any.
            d_cmd_in.hdr  = e_cpos == '0;
            d_cmd_in.idx  = e_frag;
            d_cmd_in.span = GROUP_SPAN[7:0];
            d_cmd_in.pend = chunk_end;
            d_cmd_in.fend = last && (e_gc == '0);
            d_we_in       = e_gc != '0;
            d_first_in    = e_first;
            if (chunk_end) begin
               cpos_in = '0;
               frag_in = e_frag + 16'd1;
               if (e_gc != '0) begin
                  if (cg_wrap) begin
                     cg_in    = '0;
                     base_in  = '0;
                     first_in = 1'b0;
                  end else begin
                     cg_in   = e_cg + CG_W'(1);
                     base_in = e_base + ADDR_W'(CHUNK_BYTES);
                  end
               end
            end else begin
               cpos_in = e_cpos + CP_W'(1);
            end
            if (last && e_gc != '0) begin
               dgrp_in  = GC_W'(1);
               dpos_in  = '0;
               dbase_in = '0;
            end
         end
         offset_in = last ? '0 : offset_ff + 27'd1;
      end
   end

   // Stage C and D registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff       <= 1'b0;
         lw_v_ff      <= 1'b0;
         vseq_ff      <= '0;
         aseq_ff      <= '0;
         offset_ff    <= '0;
         frag_ff      <= '0;
         cpos_ff      <= '0;
         gc_ff        <= '0;
         cg_ff        <= '0;
         base_ff      <= '0;
         first_ff     <= 1'b1;
         lat_ts_ff    <= '0;
         lat_size_ff  <= '0;
         lat_cnt_ff   <= '0;
         lat_seq_ff   <= '0;
         lat_flags_ff <= '0;
         dgrp_ff      <= '0;
         dpos_ff      <= '0;
         dbase_ff     <= '0;
      end else begin
         d_v_ff       <= d_v_in;
         lw_v_ff      <= d_v_ff && d_we_ff;
         vseq_ff      <= vseq_in;
         aseq_ff      <= aseq_in;
         offset_ff    <= offset_in;
         frag_ff      <= frag_in;
         cpos_ff      <= cpos_in;
         gc_ff        <= gc_in;
         cg_ff        <= cg_in;
         base_ff      <= base_in;
         first_ff     <= first_in;
         lat_ts_ff    <= lat_ts_in;
         lat_size_ff  <= lat_size_in;
         lat_cnt_ff   <= lat_cnt_in;
         lat_seq_ff   <= lat_seq_in;
         lat_flags_ff <= lat_flags_in;
         dgrp_ff      <= dgrp_in;
         dpos_ff      <= dpos_in;
         dbase_ff     <= dbase_in;
      end
      d_cmd_ff   <= d_cmd_in;
      d_par_ff   <= d_par_in;
      d_we_ff    <= d_we_in;
      d_first_ff <= d_first_in;
      d_addr_ff  <= d_addr_in;
      lw_addr_ff <= d_addr_ff;
      lw_data_ff <= par_wdata;
   end

   // Parity store.
   fxf_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_parity_ram (
      .clock(clock),
      .we   (d_v_ff && d_we_ff),
      .waddr(d_addr_ff),
      .wdata(par_wdata),
      .re   (1'b1),
      .raddr(c_raddr),
      .rdata(ram_rdata)
   );

   // Stage D: bypass the write of the previous cycle, fold the byte, push.
   always_comb begin
      rd_fwd    = (lw_v_ff && lw_addr_ff == d_addr_ff) ? lw_data_ff : ram_rdata;
      par_wdata = d_first_ff ? d_cmd_ff.data : (rd_fwd ^ d_cmd_ff.data);
      out_cmd   = d_cmd_ff;
      if (d_par_ff) begin
         out_cmd.data = rd_fwd;
      end
      cmd_push.valid = d_v_ff;
      cmd_push.cmd   = out_cmd;
   end

endmodule

### design/fxf_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Uses fxf_pkg; pushes are never issued when it is full (credit in the front).
module fxf_cmd_fifo
   import fxf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  fxf_push_type         push,
   input  logic                 pop,
   output fxf_cmd_type          head,
   output logic                 empty,
   output logic [CMD_CNT_W-1:0] count
);

   localparam int PTR_W = $clog2(CMD_DEPTH);

   fxf_cmd_type          mem_ff [CMD_DEPTH];
   logic [PTR_W-1:0]     wp_ff, rp_ff;
   logic [CMD_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 do_pop;

   assign do_pop = pop && cnt_ff != '0;

   // Occupancy follows pushes and pops.
   always_comb begin
      cnt_in = cnt_ff;
      case ({push.valid, do_pop})
         2'b10:   cnt_in = cnt_ff + CMD_CNT_W'(1);
         2'b01:   cnt_in = cnt_ff - CMD_CNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   // Pointers, count and storage.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push.valid) begin
            wp_ff <= wp_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rp_ff <= rp_ff + PTR_W'(1);
         end
      end
      if (push.valid) begin
         mem_ff[wp_ff] <= push.cmd;
      end
   end

   assign head  = mem_ff[rp_ff];
   assign empty = cnt_ff == '0;
   assign count = cnt_ff;

endmodule

### design/fxf_back.sv
// Back end: turns each command into any header bytes and its payload byte.
// Uses fxf_pkg; reads the head of the command queue.
module fxf_back
   import fxf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  fxf_cmd_type head,
   input  logic        empty,
   input  logic        rsp_pop,
   output logic        cmd_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_packet_end,
   output logic        rsp_frame_end,
   output logic        rsp_run_last,
   output logic        rsp_rejected
);

   logic [4:0] pos_ff, pos_in;
   logic       in_hdr, xfer;
   logic [7:0] hbyte;
   logic [31:0] size32;

   assign size32 = {5'd0, head.size};
   assign in_hdr = head.hdr && (pos_ff < 5'(HDR_BYTES));
   assign xfer   = rsp_pop && !empty;

   // Header byte at the current position, big-endian fields.
   always_comb begin
      case (pos_ff)
         5'd0:    hbyte = MAGIC_0;
         5'd1:    hbyte = MAGIC_1;
         5'd2:    hbyte = MAGIC_2;
         5'd3:    hbyte = MAGIC_3;
         5'd4:    hbyte = head.seq[31:24];
         5'd5:    hbyte = head.seq[23:16];
         5'd6:    hbyte = head.seq[15:8];
         5'd7:    hbyte = head.seq[7:0];
         5'd8:    hbyte = head.ts[63:56];
         5'd9:    hbyte = head.ts[55:48];
         5'd10:   hbyte = head.ts[47:40];
         5'd11:   hbyte = head.ts[39:32];
         5'd12:   hbyte = head.ts[31:24];
         5'd13:   hbyte = head.ts[23:16];
         5'd14:   hbyte = head.ts[15:8];
         5'd15:   hbyte = head.ts[7:0];
         5'd16:   hbyte = head.flags;
         5'd17:   hbyte = head.idx[15:8];
         5'd18:   hbyte = head.idx[7:0];
         5'd19:   hbyte = head.cnt[15:8];
         5'd20:   hbyte = head.cnt[7:0];
         5'd21:   hbyte = size32[31:24];
         5'd22:   hbyte = size32[23:16];
         5'd23:   hbyte = size32[15:8];
         5'd24:   hbyte = size32[7:0];
         5'd25:   hbyte = head.span;
         default: hbyte = 8'h00;
      endcase
   end

   // Result ports and position within the command.
   always_comb begin
      pos_in  = pos_ff;
      cmd_pop = 1'b0;
      if (in_hdr) begin
         rsp_out_byte   = hbyte;
         rsp_packet_end = 1'b0;
         rsp_frame_end  = 1'b0;
         rsp_run_last   = 1'b0;
         rsp_rejected   = 1'b0;
         if (xfer) begin
            pos_in = pos_ff + 5'd1;
         end
      end else begin
         rsp_out_byte   = head.data;
         rsp_packet_end = head.pend;
         rsp_frame_end  = head.fend;
         rsp_run_last   = 1'b1;
         rsp_rejected   = head.rej;
         if (xfer) begin
            pos_in  = '0;
            cmd_pop = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

### design/frame_packetizer_xor_fec.sv
// Frame packetizer with interleaved XOR parity packets.
// Results come out of the queue; items reach it through registers A, B and D.
// Throughput: one item per cycle into the front while full is low; results
// leave one per cycle while popped; a packet-opening item yields 29 (header, byte).
// Reset is synchronous and active high; it clears sequences and framing state.
// The parity RAM needs no clearing; only positions written this frame are read.
module frame_packetizer_xor_fec
   import fxf_pkg::*;
#(
   parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
   parameter int GROUP_SPAN  = GROUP_SPAN_DEF,
   parameter int MAX_GROUPS  = MAX_GROUPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        full,
   input  logic        req_func,
   input  logic [7:0]  req_data_byte,
   input  logic [26:0] req_frame_size,
   input  logic [63:0] req_timestamp_ms,
   input  logic        req_is_keyframe,
   input  logic        req_is_codec_config,
   input  logic        req_is_hevc,
   input  logic        req_is_audio,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_packet_end,
   output logic        rsp_frame_end,
   output logic        rsp_run_last,
   output logic        rsp_rejected
);

   fxf_item_type         item;
   fxf_push_type         cmd_push;
   fxf_cmd_type          head;
   logic [CMD_CNT_W-1:0] cmd_count;
   logic                 cmd_pop;
   logic                 accept;

   assign accept = req_push && !full;

   always_comb begin
      item.func            = req_func;
      item.data_byte       = req_data_byte;
      item.frame_size      = req_frame_size;
      item.timestamp_ms    = req_timestamp_ms;
      item.is_keyframe     = req_is_keyframe;
      item.is_codec_config = req_is_codec_config;
      item.is_hevc         = req_is_hevc;
      item.is_audio        = req_is_audio;
   end

   fxf_front #(
      .CHUNK_BYTES(CHUNK_BYTES),
      .GROUP_SPAN (GROUP_SPAN),
      .MAX_GROUPS (MAX_GROUPS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_accept(accept),
      .in_item  (item),
      .cmd_count(cmd_count),
      .full     (full),
      .cmd_push (cmd_push)
   );

   fxf_cmd_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push (cmd_push),
      .pop  (cmd_pop),
      .head (head),
      .empty(empty),
      .count(cmd_count)
   );

   fxf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .empty         (empty),
      .rsp_pop       (pop),
      .cmd_pop       (cmd_pop),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_packet_end(rsp_packet_end),
      .rsp_frame_end (rsp_frame_end),
      .rsp_run_last  (rsp_run_last),
      .rsp_rejected  (rsp_rejected)
   );

   // The credit scheme must keep every queue push within capacity.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd_push.valid |-> (cmd_count < CMD_CNT_W'(CMD_DEPTH)))
      else $error("command pushed into a full queue");

   // A rejection is a lone zero result that closes its item's run.
   a_reject_form: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_rejected) |-> (rsp_run_last && rsp_out_byte == 8'h00
                                    && !rsp_packet_end))
      else $error("malformed rejection result");

   // Header bytes never close a packet or a frame.
   a_hdr_no_end: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_run_last) |-> (!rsp_packet_end && !rsp_frame_end))
      else $error("packet end on a header byte");

   // A frame end is always also a packet end.
   a_frame_pkt: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_frame_end) |-> rsp_packet_end)
      else $error("frame end without packet end");

endmodule

### sim/frame_packetizer_xor_fec_tb.sv
// Self-checking testbench for frame_packetizer_xor_fec: directed table, then random frames.
// Depends on fxf_pkg and the block's RTL; expected bytes come from an in-bench packetizer model.
`timescale 1ns / 100ps

module frame_packetizer_xor_fec_tb;
   import fxf_pkg::*;

   localparam int CHUNK     = 1300;
   localparam int SPAN      = 8;
   localparam int GROUPS    = 64;
   localparam int IDLE_MAX  = 20000;
   localparam int MAX_FRAME = 85195500;

   typedef struct packed {
      logic [7:0] b;
      logic       pend;
      logic       fend;
      logic       last;
      logic       rej;
   } pkt_byte_type;

   typedef enum logic [1:0] {ROW_MODEL, ROW_REJECT, ROW_SILENT} row_kind_type;

   typedef struct packed {
      fxf_item_type item;
      row_kind_type kind;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        full;
   logic        req_func = FUNC_PAYLOAD;
   logic [7:0]  req_data_byte = '0;
   logic [26:0] req_frame_size = '0;
   logic [63:0] req_timestamp_ms = '0;
   logic        req_is_keyframe = 1'b0;
   logic        req_is_codec_config = 1'b0;
   logic        req_is_hevc = 1'b0;
   logic        req_is_audio = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_packet_end;
   logic        rsp_frame_end;
   logic        rsp_run_last;
   logic        rsp_rejected;

   pkt_byte_type out_bytes_due[$];
   row_type      rows[$];
   int           errors = 0;
   int           idle_cycles = 0;
   int           pop_wait = 0;
   bit           burst = 1'b0;

   // Packetizer state mirrored from the block's behavior.
   int unsigned  video_seq, audio_seq, frame_pos, frag_num, chunk_pos;
   int unsigned  num_groups, cur_group, drain_grp, drain_pos;
   logic [63:0]  hdr_ts;
   int unsigned  hdr_size, hdr_cnt, hdr_seq;
   logic [7:0]   hdr_flags;
   logic [7:0]   parity_mem [GROUPS * CHUNK];
   int unsigned  parity_len [GROUPS];

   frame_packetizer_xor_fec dut (.*);

   always #5 clock = ~clock;

   function automatic int draw_gap();
      return burst ? 0 : $urandom_range(0, 7);
   endfunction

   function automatic void put_byte(logic [7:0] b, logic pend, logic fend, logic rej);
      out_bytes_due.push_back('{b: b, pend: pend, fend: fend, last: 1'b0, rej: rej});
   endfunction

   // Emits the 28 header bytes from the latched frame attributes.
   function automatic void put_header(logic [7:0] flags, logic [15:0] idx, logic [7:0] span);
      logic [8*HDR_BYTES-1:0] h;
      h = {MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3, hdr_seq[31:0], hdr_ts, flags, idx,
           hdr_cnt[15:0], hdr_size[31:0], span, 16'h0000};
      for (int i = HDR_BYTES - 1; i >= 0; i--) put_byte(h[8*i +: 8], 1'b0, 1'b0, 1'b0);
   endfunction

   // Queues the output bytes that one accepted transfer must produce.
   function automatic void predict_packets(fxf_item_type it);
      int unsigned start, g, pos, fs;
      logic        last, cend;
      start = out_bytes_due.size();
      if (it.func == FUNC_PULL) begin
         if (drain_grp != 0) begin
            g = drain_grp - 1;
            if (drain_pos == 0) put_header(hdr_flags | FLAG_PARITY, g[15:0], 8'(SPAN));
            pos = drain_pos < CHUNK ? drain_pos : 0;
            last = drain_pos + 1 >= parity_len[g];
            put_byte(parity_mem[g * CHUNK + pos], last, last && g + 1 >= num_groups, 1'b0);
            if (last) begin
               drain_pos = 0;
               drain_grp = (g + 1 >= num_groups) ? 0 : drain_grp + 1;
            end else begin
               drain_pos++;
            end
         end
      end else if (drain_grp != 0 || (frame_pos == 0 && it.frame_size == 0)) begin
         put_byte(8'h00, 1'b0, 1'b0, 1'b1);
      end else begin
         // A frame's first byte latches its header fields.
         if (frame_pos == 0) begin
            fs = it.frame_size;
            if (it.is_audio) begin
               audio_seq++;
               hdr_seq = audio_seq;
               hdr_flags = AUD_FLAG | (it.is_codec_config ? AUD_CFG_FLAG : 8'h00);
               hdr_cnt = 1;
               num_groups = 0;
            end else begin
               video_seq++;
               hdr_seq = video_seq;
               hdr_flags = (it.is_keyframe ? FLAG_KEY : 8'h00)
                         | (it.is_codec_config && !it.is_keyframe ? FLAG_CFG : 8'h00)
                         | (it.is_hevc ? FLAG_HEVC : 8'h00);
               hdr_cnt = (fs + CHUNK - 1) / CHUNK;
               num_groups = 0;
               if (hdr_cnt > 1) begin
                  num_groups = (hdr_cnt + SPAN - 1) / SPAN;
                  if (num_groups > GROUPS) num_groups = GROUPS;
               end
            end
            hdr_ts = it.timestamp_ms;
            hdr_size = fs;
            frag_num = 0;
            chunk_pos = 0;
            cur_group = 0;
            foreach (parity_len[i]) parity_len[i] = 0;
         end
         last = frame_pos + 1 >= hdr_size;
         if ((hdr_flags & AUD_FLAG) != 8'h00) begin
            if (frame_pos == 0) put_header(hdr_flags, 16'h0000, 8'h00);
            put_byte(it.data_byte, last, last, 1'b0);
         end else begin
            cend = last || chunk_pos + 1 >= CHUNK;
            if (chunk_pos == 0) put_header(hdr_flags, frag_num[15:0], 8'(SPAN));
            // Fold the byte into its parity group; first touch just stores it.
            if (num_groups > 0) begin
               if (chunk_pos >= parity_len[cur_group]) begin
                  parity_mem[cur_group * CHUNK + chunk_pos] = it.data_byte;
                  parity_len[cur_group] = chunk_pos + 1;
               end else begin
                  parity_mem[cur_group * CHUNK + chunk_pos] ^= it.data_byte;
               end
            end
            put_byte(it.data_byte, cend, last && num_groups == 0, 1'b0);
            if (cend) begin
               chunk_pos = 0;
               frag_num++;
               if (num_groups > 0) cur_group = (cur_group + 1 >= num_groups) ? 0 : cur_group + 1;
            end else begin
               chunk_pos++;
            end
            if (last && num_groups > 0) begin
               drain_grp = 1;
               drain_pos = 0;
            end
         end
         frame_pos = last ? 0 : frame_pos + 1;
      end
      if (out_bytes_due.size() > start) out_bytes_due[out_bytes_due.size() - 1].last = 1'b1;
   endfunction

   function automatic fxf_item_type make_item(logic func, logic [7:0] data, int unsigned size,
                                              logic [63:0] ts, logic key, logic cfg,
                                              logic hevc, logic aud);
      fxf_item_type it;
      it.func = func;
      it.data_byte = data;
      it.frame_size = size[26:0];
      it.timestamp_ms = ts;
      it.is_keyframe = key;
      it.is_codec_config = cfg;
      it.is_hevc = hevc;
      it.is_audio = aud;
      return it;
   endfunction

   function automatic fxf_item_type random_item(logic func);
      return make_item(func, $urandom_range(0, 255), $urandom() & 32'h7FF_FFFF,
                       {$urandom(), $urandom()}, $urandom_range(0, 1), $urandom_range(0, 1),
                       $urandom_range(0, 1), $urandom_range(0, 1));
   endfunction

   // Drives one item and holds it until the block takes the transfer.
   task automatic send(fxf_item_type it, bit use_model = 1'b1);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_func <= it.func;
      req_data_byte <= it.data_byte;
      req_frame_size <= it.frame_size;
      req_timestamp_ms <= it.timestamp_ms;
      req_is_keyframe <= it.is_keyframe;
      req_is_codec_config <= it.is_codec_config;
      req_is_hevc <= it.is_hevc;
      req_is_audio <= it.is_audio;
      do @(posedge clock); while (full);
      if (use_model) predict_packets(it);
   endtask

   // Sends a whole frame; attributes on later bytes are random since they are ignored.
   task automatic send_frame(int unsigned size, logic aud);
      fxf_item_type first;
      first = random_item(FUNC_PAYLOAD);
      first.frame_size = size[26:0];
      first.is_audio = aud;
      send(first);
      for (int unsigned k = 1; k < size; k++) send(random_item(FUNC_PAYLOAD));
   endtask

   // Pulls every pending parity byte, with a few payload bytes that must be refused.
   task automatic drain_parity();
      while (drain_grp != 0)
         send(random_item($urandom_range(0, 15) == 0 ? FUNC_PAYLOAD : FUNC_PULL));
   endtask

   // Receiver side: random pop stalls and the per-field comparison.
   always @(posedge clock) begin
      pkt_byte_type e;
      if (!reset) begin
         if (pop && !empty) begin
            if (out_bytes_due.size() == 0) begin
               $error("unexpected result byte %02h", rsp_out_byte);
               errors++;
            end else begin
               e = out_bytes_due.pop_front();
               if (rsp_out_byte !== e.b) begin
                  $error("out_byte: expected %02h, got %02h", e.b, rsp_out_byte);
                  errors++;
               end
               if (rsp_packet_end !== e.pend) begin
                  $error("packet_end: expected %0b, got %0b", e.pend, rsp_packet_end);
                  errors++;
               end
               if (rsp_frame_end !== e.fend) begin
                  $error("frame_end: expected %0b, got %0b", e.fend, rsp_frame_end);
                  errors++;
               end
               if (rsp_run_last !== e.last) begin
                  $error("run_last: expected %0b, got %0b", e.last, rsp_run_last);
                  errors++;
               end
               if (rsp_rejected !== e.rej) begin
                  $error("rejected: expected %0b, got %0b", e.rej, rsp_rejected);
                  errors++;
               end
            end
            pop_wait = draw_gap();
         end
         if (pop_wait > 0) begin
            pop <= 1'b0;
            pop_wait--;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      video_seq = 0; audio_seq = 0; frame_pos = 0; frag_num = 0; chunk_pos = 0;
      num_groups = 0; cur_group = 0; drain_grp = 0; drain_pos = 0;
      hdr_ts = '0; hdr_size = 0; hdr_cnt = 0; hdr_seq = 0; hdr_flags = '0;
      foreach (parity_len[i]) parity_len[i] = 0;

      // Directed table: silent pull, zero-size refusal, extremes of each frame kind.
      rows.push_back('{make_item(FUNC_PULL, 8'hFF, 5, '1, 1, 1, 1, 1), ROW_SILENT});
      rows.push_back('{make_item(FUNC_PAYLOAD, 8'h5A, 0, '0, 0, 0, 0, 0), ROW_REJECT});
      rows.push_back('{make_item(FUNC_PAYLOAD, 8'hFF, 1, '1, 0, 1, 0, 1), ROW_MODEL});
      rows.push_back('{make_item(FUNC_PAYLOAD, 8'h00, 1, '0, 1, 1, 1, 0), ROW_MODEL});
      rows.push_back('{make_item(FUNC_PAYLOAD, 8'hA5, 1, 64'h0123456789ABCDEF, 0, 1, 0, 0),
                       ROW_MODEL});
      rows.push_back('{make_item(FUNC_PAYLOAD, 8'h01, 3, '1, 0, 0, 1, 0), ROW_MODEL});
      rows.push_back('{make_item(FUNC_PAYLOAD, 8'h80, '1, '0, 1, 0, 0, 1), ROW_MODEL});
      rows.push_back('{make_item(FUNC_PAYLOAD, 8'h7F, 0, '0, 0, 0, 0, 1), ROW_MODEL});
      rows.push_back('{make_item(FUNC_PAYLOAD, 8'h33, 2, '1, 0, 0, 0, 1), ROW_MODEL});
      rows.push_back('{make_item(FUNC_PAYLOAD, 8'hCC, 9, '0, 1, 1, 1, 0), ROW_MODEL});
      rows.push_back('{make_item(FUNC_PULL, 8'h00, 0, '0, 0, 0, 0, 0), ROW_SILENT});

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         send(rows[i].item, rows[i].kind == ROW_MODEL);
         if (rows[i].kind == ROW_REJECT) begin
            put_byte(8'h00, 1'b0, 1'b0, 1'b1);
            out_bytes_due[out_bytes_due.size() - 1].last = 1'b1;
         end
      end

      // Random small frames, with stray pulls and zero-size starts as noise.
      for (int n = 0; n < 230; ) begin
         burst = $urandom_range(0, 5) == 0;
         case ($urandom_range(0, 9))
            0: begin
               send(random_item(FUNC_PULL));
               n++;
            end
            1: begin
               fxf_item_type z;
               z = random_item(FUNC_PAYLOAD);
               z.frame_size = 0;
               send(z);
               n++;
            end
            default: begin
               int unsigned sz;
               sz = $urandom_range(1, 24);
               send_frame(sz, $urandom_range(0, 2) == 0);
               n += sz;
            end
         endcase
      end
      burst = 1'b0;

      // Hold the sender until the output has caught up.
      req_push <= 1'b0;
      while (out_bytes_due.size() != 0) @(posedge clock);

      // Multi-chunk video: one parity group, then two groups of unequal length.
      send_frame($urandom_range(CHUNK + 1, 3 * CHUNK), 1'b0);
      drain_parity();
      send_frame(8 * CHUNK + $urandom_range(1, CHUNK), 1'b0);
      drain_parity();
      send_frame($urandom_range(1, 5), 1'b1);

      // Largest frame size with a 16-bit fragment count: only its opening byte is sent.
      begin
         fxf_item_type big;
         big = random_item(FUNC_PAYLOAD);
         big.frame_size = MAX_FRAME;
         big.is_audio = 1'b0;
         send(big);
      end
      req_push <= 1'b0;

      while (out_bytes_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

### frame_packetizer_xor_fec.f
design/fxf_pkg.sv
design/fxf_ram.sv
design/fxf_front.sv
design/fxf_cmd_fifo.sv
design/fxf_back.sv
design/frame_packetizer_xor_fec.sv
sim/frame_packetizer_xor_fec_tb.sv
